// ===== hw/rtl/sac_pkg.sv =====
// Shared types and constants for the swept AABB collision pipeline.
`timescale 1ns / 1ps
package sac_pkg;
  localparam int DistW = 26;
  localparam int VelW  = 17;
  localparam int DividendW = DistW + 16;
  localparam int TimeW = 44;
  localparam logic signed [TimeW-1:0] InfPos = {2'b01, {(TimeW-2){1'b0}}};
  localparam logic signed [TimeW-1:0] InfNeg = -InfPos;
  localparam logic signed [TimeW-1:0] OneQ16 = TimeW'(65536);

  typedef enum logic [2:0] {
    SIDE_NONE   = 3'd0,
    SIDE_RIGHT  = 3'd1,
    SIDE_LEFT   = 3'd2,
    SIDE_TOP    = 3'd3,
    SIDE_BOTTOM = 3'd4
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [TimeW-1:0] v);
    logic signed [TimeW-1:0] lo;
    logic signed [TimeW-1:0] hi;
    lo = -(TimeW'(64'sh80000000));
    hi = TimeW'(64'sh7fffffff);
    if (v > hi) sat32 = 32'sh7fffffff;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction
endpackage

// ===== hw/rtl/sac_div.sv =====
// Pipelined restoring signed divider, one quotient bit per stage, truncating toward zero.
`timescale 1ns / 1ps
module sac_div import sac_pkg::*; #(
  parameter int NW = 42,
  parameter int DW = 17,
  parameter int TW = 8
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  input  logic [TW-1:0]        tag_in,
  output logic signed [NW-1:0] quo,
  output logic [TW-1:0]        tag_out
);
  logic [NW-1:0] q_r   [NW+1];
  logic [DW-1:0] rm_r  [NW+1];
  logic [DW-1:0] d_r   [NW+1];
  logic          neg_r [NW+1];
  logic [TW-1:0] tag_r [NW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0]   <= num[NW-1] ? NW'(-num) : num;
      rm_r[0]  <= '0;
      d_r[0]   <= den[DW-1] ? DW'(-den) : den;
      neg_r[0] <= num[NW-1] ^ den[DW-1];
      tag_r[0] <= tag_in;
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [DW:0] trial;
    logic [DW:0] rsh;
    assign rsh   = {rm_r[i], q_r[i][NW-1]};
    assign trial = rsh - {1'b0, d_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rm_r[i+1]  <= trial[DW] ? rsh[DW-1:0] : trial[DW-1:0];
        q_r[i+1]   <= {q_r[i][NW-2:0], ~trial[DW]};
        d_r[i+1]   <= d_r[i];
        neg_r[i+1] <= neg_r[i];
        tag_r[i+1] <= tag_r[i];
      end
    end
  end

  assign quo     = neg_r[NW] ? -$signed(q_r[NW]) : $signed(q_r[NW]);
  assign tag_out = tag_r[NW];
endmodule

// ===== hw/rtl/sac_front.sv =====
// Front stages: broadphase sweep, relative velocity and axis distances.
`timescale 1ns / 1ps
module sac_front import sac_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [23:0]      a_top, a_left, a_bottom, a_right,
  input  logic signed [15:0]      a_vel_x, a_vel_y,
  input  logic signed [23:0]      b_top, b_left, b_bottom, b_right,
  input  logic [31:0]             b_vel_packed,
  input  logic [15:0]             frame_time,
  output logic                    miss_o,
  output logic signed [VelW-1:0]  rvx_o, rvy_o,
  output logic signed [DistW-1:0] xen_o, xex_o, yen_o, yex_o
);
  // stage 1: sweep products, edge copies, relative velocity
  logic signed [32:0] dx_r, dy_r;
  logic signed [23:0] at_r, al_r, ab_r, ar_r, bt_r, bl_r, bb_r, br_r;
  logic signed [VelW-1:0] rvx_r, rvy_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= a_vel_x * $signed({1'b0, frame_time});
      dy_r <= a_vel_y * $signed({1'b0, frame_time});
      at_r <= a_top; al_r <= a_left; ab_r <= a_bottom; ar_r <= a_right;
      bt_r <= b_top; bl_r <= b_left; bb_r <= b_bottom; br_r <= b_right;
      rvx_r <= VelW'(a_vel_x) - VelW'($signed(b_vel_packed[31:16]));
      rvy_r <= VelW'(a_vel_y) - VelW'($signed(b_vel_packed[15:0]));
    end
  end

  // stage 2: overlap test and distances
  logic signed [33:0] t16, l16, b16, r16, pt, pl, pb, pr;
  always_comb begin
    t16 = 34'($signed({at_r, 8'h00})); l16 = 34'($signed({al_r, 8'h00}));
    b16 = 34'($signed({ab_r, 8'h00})); r16 = 34'($signed({ar_r, 8'h00}));
    pt = (dy_r > 0) ? t16 + 34'(dy_r) : t16;
    pb = (dy_r < 0) ? b16 + 34'(dy_r) : b16;
    pl = (dx_r < 0) ? l16 + 34'(dx_r) : l16;
    pr = (dx_r > 0) ? r16 + 34'(dx_r) : r16;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      miss_o <= (34'($signed({bl_r, 8'h00})) > pr) ||
                (34'($signed({br_r, 8'h00})) < pl) ||
                (34'($signed({bt_r, 8'h00})) < pb) ||
                (34'($signed({bb_r, 8'h00})) > pt);
      rvx_o <= rvx_r; rvy_o <= rvy_r;
      xen_o <= (rvx_r >= 0) ? DistW'(bl_r) - DistW'(ar_r) : DistW'(br_r) - DistW'(al_r);
      xex_o <= (rvx_r >= 0) ? DistW'(br_r) - DistW'(al_r) : DistW'(bl_r) - DistW'(ar_r);
      yen_o <= (rvy_r >= 0) ? DistW'(bb_r) - DistW'(at_r) : DistW'(bt_r) - DistW'(ab_r);
      yex_o <= (rvy_r >= 0) ? DistW'(bt_r) - DistW'(ab_r) : DistW'(bb_r) - DistW'(at_r);
    end
  end
endmodule

// ===== hw/rtl/swept_aabb_collision.sv =====
// Top level of the swept AABB collision pipeline.
//  channel | direction | handshake
//  in_     | request   | in_valid / in_ready
//  out_    | result    | out_valid / out_ready
// One request enters per cycle unless a stall on out_ready holds it; the pipeline has 2 front
// stages, 43 divider stages, 1 resolve stage and an output register. The divider depth,
// one quotient bit per stage, sets the latency. Reset clears the valid bits.
// A stall on out_ready freezes the whole pipeline; in_ready falls whenever
// the output register holds a result that is not taken.
`timescale 1ns / 1ps
module swept_aabb_collision import sac_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_a_top, in_a_left, in_a_bottom, in_a_right,
  input  logic signed [15:0] in_a_vel_x, in_a_vel_y,
  input  logic signed [23:0] in_b_top, in_b_left, in_b_bottom, in_b_right,
  input  logic [31:0]        in_b_vel_packed,
  input  logic [15:0]        in_frame_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic [2:0]         out_side,
  output logic signed [31:0] out_entry_time,
  output logic signed [31:0] out_exit_time,
  output logic signed [31:0] out_remaining_time
);
  localparam int Depth = 2 + DividendW + 1 + 2;
  logic [Depth-1:0] vld_r;
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[Depth-2:0], in_valid};
  end

  logic miss;
  logic signed [VelW-1:0] rvx, rvy;
  logic signed [DistW-1:0] xen, xex, yen, yex;
  sac_front u_front (
    .clk, .en,
    .a_top(in_a_top), .a_left(in_a_left), .a_bottom(in_a_bottom), .a_right(in_a_right),
    .a_vel_x(in_a_vel_x), .a_vel_y(in_a_vel_y),
    .b_top(in_b_top), .b_left(in_b_left), .b_bottom(in_b_bottom), .b_right(in_b_right),
    .b_vel_packed(in_b_vel_packed), .frame_time(in_frame_time),
    .miss_o(miss), .rvx_o(rvx), .rvy_o(rvy),
    .xen_o(xen), .xex_o(xex), .yen_o(yen), .yex_o(yex)
  );

  logic signed [VelW-1:0] rvx_den, rvy_den;
  logic signed [DividendW-1:0] qxen, qxex, qyen, qyex;
  logic m_a, zx, zy;
  logic [1:0] pos_a;
  assign rvx_den = (rvx == 0) ? VelW'(1) : rvx;
  assign rvy_den = (rvy == 0) ? VelW'(1) : rvy;

  sac_div #(.NW(DividendW), .DW(VelW), .TW(1)) u_dxen (
    .clk, .en, .num({xen, 16'h0}), .den(rvx_den),
    .tag_in(miss), .quo(qxen), .tag_out(m_a));
  sac_div #(.NW(DividendW), .DW(VelW), .TW(1)) u_dxex (
    .clk, .en, .num({xex, 16'h0}), .den(rvx_den),
    .tag_in(rvx == 0), .quo(qxex), .tag_out(zx));
  sac_div #(.NW(DividendW), .DW(VelW), .TW(1)) u_dyen (
    .clk, .en, .num({yen, 16'h0}), .den(rvy_den),
    .tag_in(rvy == 0), .quo(qyen), .tag_out(zy));
  sac_div #(.NW(DividendW), .DW(VelW), .TW(2)) u_dyex (
    .clk, .en, .num({yex, 16'h0}), .den(rvy_den),
    .tag_in({xen > 0, yen > 0}), .quo(qyex), .tag_out(pos_a));

  // resolve stage A: infinities and min/max
  logic signed [TimeW-1:0] txen, txex, tyen, tyex;
  always_comb begin
    txen = zx ? InfNeg : TimeW'(qxen);
    txex = zx ? InfPos : TimeW'(qxex);
    tyen = zy ? InfNeg : TimeW'(qyen);
    tyex = zy ? InfPos : TimeW'(qyex);
  end
  logic signed [TimeW-1:0] ent_r, ext_r;
  logic m_r, nohit_r, xside_r, xpos_r, ypos_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ent_r   <= (txen > tyen) ? txen : tyen;
      ext_r   <= (txex < tyex) ? txex : tyex;
      nohit_r <= (txen < 0 && tyen < 0) || txen > OneQ16 || tyen > OneQ16;
      xside_r <= txen > tyen;
      xpos_r  <= pos_a[1];
      ypos_r  <= pos_a[0];
      m_r     <= m_a;
    end
  end

  // resolve stage B and output register
  logic hit_b;
  side_t side_b;
  always_comb begin
    hit_b = !m_r && !nohit_r && !(ent_r > ext_r);
    if (!hit_b) side_b = SIDE_NONE;
    else if (xside_r) side_b = xpos_r ? SIDE_RIGHT : SIDE_LEFT;
    else side_b = ypos_r ? SIDE_TOP : SIDE_BOTTOM;
  end
  logic [2:0] side_q;
  always_ff @(posedge clk) begin
    if (en) begin
      out_hit            <= hit_b;
      side_q             <= side_b;
      out_entry_time     <= m_r ? 32'sd0 : sat32(ent_r);
      out_exit_time      <= m_r ? 32'sd0 : sat32(ext_r);
      out_remaining_time <= m_r ? 32'sd0 : sat32(OneQ16 - ent_r);
    end
  end
  assign out_side  = side_q;
  assign out_valid = vld_r[Depth-1];

`ifndef SYNTHESIS
  a_hit_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit == (out_side != SIDE_NONE))) else $error("hit/side mismatch");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_time)) else $error("stall lost");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("ready low while empty");
`endif
endmodule
